// ----- hw/rtl/spld3_pkg.sv -----
package spld3_pkg;
    localparam int DIST_BITS = 19;
    localparam int IN_BITS   = 10;
endpackage

// ----- hw/rtl/staircase_path_line_deviation_3d_top.sv -----
// channel | dir | tdata fields (lsb first)
// s_axis  | in  | start_x, start_y, start_z, end_x, end_y, end_z (60 bits, 64 wide)
// m_axis  | out | max_distance (19 bits, 24 wide); tuser: degenerate
// per path point S_M0..S_M5 and S_SQ build |cross|^2, S_ST keeps the max; S_VV sums
// |v|^2; each of the 19 result bits runs S_T, S_TV, S_CMP; one multiplier is shared
// reset is synchronous, active low, and clears the sequencer and the output valid
// the block takes a request only when idle; a waiting result holds it at the output stage
module staircase_path_line_deviation_3d_top
    import spld3_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // max_distance
    output logic        m_axis_tuser    // degenerate
);
    // coordinates never carry more bits than the input fields
    localparam int CB = (COORD_BITS < IN_BITS) ? COORD_BITS : IN_BITS;
    localparam int DB = CB + 1;             // signed difference
    localparam int PB = 2 * CB + 2;         // signed product
    localparam int CRB = PB + 1;            // signed cross component
    localparam int SQB = 2 * CRB;           // squared width
    localparam int MB = 2 * CRB + 2;        // running sum and max
    localparam int NB = MB + 2 * FRAC_BITS; // shifted numerator
    localparam int VB = 2 * DB + 2;         // |v|^2
    localparam int RB = DIST_BITS;
    localparam int TB = 2 * RB;
    localparam int QB = TB + VB;
    localparam int CMPB = (NB > QB) ? NB : QB;
    localparam int MULA = (CRB > TB) ? CRB : TB;
    localparam int MULB = (CRB > VB) ? CRB : VB;

    localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
        S_M3 = 4'd4, S_M4 = 4'd5, S_M5 = 4'd6, S_SQ = 4'd7, S_ST = 4'd8,
        S_VV = 4'd9, S_T = 4'd10, S_TV = 4'd11, S_CMP = 4'd12, S_OUT = 4'd13;

    logic [3:0]  r_state, n_state;
    logic [CB-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_px, r_py, r_pz;
    logic signed [DB-1:0] r_vx, r_vy, r_vz;
    logic signed [PB-1:0] r_prod;
    logic signed [CRB-1:0] r_cr;
    logic [1:0]  r_comp;
    logic [MB-1:0] r_acc, r_max;
    logic [VB-1:0] r_vv;
    logic [RB-1:0] r_r;
    logic [4:0]  r_bit;
    logic [TB-1:0] r_tt;
    logic [QB-1:0] r_q;
    logic [RB-1:0] r_dist;
    logic        r_deg, r_ovalid;

    // shared multiplier operands
    logic signed [MULA:0] mul_a;
    logic signed [MULB:0] mul_b;
    logic signed [MULA+MULB+1:0] mul_p;
    logic signed [DB-1:0] dx, dy, dz;
    logic [RB-1:0] t_cand;

    assign n_state = r_state;

    assign dx = DB'(signed'({1'b0, r_ax})) - DB'(signed'({1'b0, r_px}));
    assign dy = DB'(signed'({1'b0, r_ay})) - DB'(signed'({1'b0, r_py}));
    assign dz = DB'(signed'({1'b0, r_az})) - DB'(signed'({1'b0, r_pz}));
    assign t_cand = r_r | (RB'(1) << r_bit);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (n_state)
            S_M0: begin mul_a = (MULA+1)'(dy); mul_b = (MULB+1)'(r_vz); end
            S_M1: begin mul_a = (MULA+1)'(dz); mul_b = (MULB+1)'(r_vy); end
            S_M2: begin mul_a = (MULA+1)'(dz); mul_b = (MULB+1)'(r_vx); end
            S_M3: begin mul_a = (MULA+1)'(dx); mul_b = (MULB+1)'(r_vz); end
            S_M4: begin mul_a = (MULA+1)'(dx); mul_b = (MULB+1)'(r_vy); end
            S_M5: begin mul_a = (MULA+1)'(dy); mul_b = (MULB+1)'(r_vx); end
            S_SQ: begin mul_a = (MULA+1)'(r_cr); mul_b = (MULB+1)'(r_cr); end
            S_VV: begin mul_a = (MULA+1)'(r_cr); mul_b = (MULB+1)'(r_cr); end
            S_T:  begin mul_a = (MULA+1)'({1'b0, t_cand}); mul_b = (MULB+1)'({1'b0, t_cand}); end
            S_TV: begin mul_a = (MULA+1)'({1'b0, r_tt}); mul_b = (MULB+1)'({1'b0, r_vv}); end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    logic at_end;
    assign at_end = !(r_px < r_bx) && !(r_py < r_by) && !(r_pz < r_bz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_ax <= s_axis_tdata[CB-1:0];
                    r_ay <= s_axis_tdata[IN_BITS +: CB];
                    r_az <= s_axis_tdata[2*IN_BITS +: CB];
                    r_bx <= s_axis_tdata[3*IN_BITS +: CB];
                    r_by <= s_axis_tdata[4*IN_BITS +: CB];
                    r_bz <= s_axis_tdata[5*IN_BITS +: CB];
                    r_px <= s_axis_tdata[CB-1:0];
                    r_py <= s_axis_tdata[IN_BITS +: CB];
                    r_pz <= s_axis_tdata[2*IN_BITS +: CB];
                    r_vx <= DB'(signed'({1'b0, s_axis_tdata[CB-1:0]}))
                          - DB'(signed'({1'b0, s_axis_tdata[3*IN_BITS +: CB]}));
                    r_vy <= DB'(signed'({1'b0, s_axis_tdata[IN_BITS +: CB]}))
                          - DB'(signed'({1'b0, s_axis_tdata[4*IN_BITS +: CB]}));
                    r_vz <= DB'(signed'({1'b0, s_axis_tdata[2*IN_BITS +: CB]}))
                          - DB'(signed'({1'b0, s_axis_tdata[5*IN_BITS +: CB]}));
                    r_max <= '0;
                    r_state <= S_M0;
                end
                S_M0, S_M2, S_M4: begin
                    r_prod <= PB'(mul_p);
                    r_state <= r_state + 4'd1;
                end
                S_M1, S_M3, S_M5: begin
                    r_cr <= CRB'(r_prod) - CRB'(mul_p);
                    r_comp <= (r_state == S_M1) ? 2'd0 : (r_state == S_M3) ? 2'd1 : 2'd2;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_comp == 2'd0) r_acc <= MB'(SQB'(mul_p));
                    else r_acc <= r_acc + MB'(SQB'(mul_p));
                    priority case (r_comp)
                        2'd0: r_state <= S_M2;
                        2'd1: r_state <= S_M4;
                        default: r_state <= S_ST;
                    endcase
                end
                S_ST: begin
                    // check max, then advance along the staircase
                    if (r_acc > r_max) r_max <= r_acc;
                    if (r_px < r_bx) begin r_px <= r_px + CB'(1); r_state <= S_M0; end
                    else if (r_py < r_by) begin r_py <= r_py + CB'(1); r_state <= S_M0; end
                    else if (r_pz < r_bz) begin r_pz <= r_pz + CB'(1); r_state <= S_M0; end
                    else begin
                        r_acc <= '0;
                        r_comp <= 2'd0;
                        r_cr <= CRB'(r_vx);
                        r_state <= S_VV;
                    end
                end
                S_VV: begin
                    r_acc <= r_acc + MB'(SQB'(mul_p));
                    r_comp <= r_comp + 2'd1;
                    priority case (r_comp)
                        2'd0: begin r_cr <= CRB'(r_vy); end
                        2'd1: begin r_cr <= CRB'(r_vz); end
                        default: begin
                            r_vv <= VB'(r_acc + MB'(SQB'(mul_p)));
                            r_r <= '0;
                            r_bit <= 5'(RB - 1);
                            r_state <= (r_acc + MB'(SQB'(mul_p)) == '0) ? S_OUT : S_T;
                        end
                    endcase
                end
                S_T: begin
                    r_tt <= TB'(mul_p);
                    r_state <= S_TV;
                end
                S_TV: begin
                    r_q <= QB'(mul_p);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (CMPB'(r_q) <= (CMPB'(r_max) << (2 * FRAC_BITS)))
                        r_r <= t_cand;
                    if (r_bit == 5'd0) r_state <= S_OUT;
                    else begin r_bit <= r_bit - 5'd1; r_state <= S_T; end
                end
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_dist <= r_r;
                    r_deg <= (r_vv == '0);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_dist};
    assign m_axis_tuser  = r_deg;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_deg) |-> (r_dist == '0)) else $error("degenerate with distance");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_dist)))
        else $error("result lost");
    a_path_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VV) |-> at_end) else $error("path not finished");
endmodule

// ----- tb/staircase_path_line_deviation_3d_top_tb.sv -----
module staircase_path_line_deviation_3d_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spld3_pkg::*;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;

    typedef struct packed {
        logic [IN_BITS-1:0] end_z;
        logic [IN_BITS-1:0] end_y;
        logic [IN_BITS-1:0] end_x;
        logic [IN_BITS-1:0] start_z;
        logic [IN_BITS-1:0] start_y;
        logic [IN_BITS-1:0] start_x;
    } t_segment;

    typedef struct {
        logic [DIST_BITS-1:0] max_distance;
        logic                 degenerate;
    } t_deviation;

    class t_deviation_scoreboard;
        t_deviation pending[$];
        int         errors = 0;

        function logic [127:0] cross_norm(longint a[3], longint v[3], longint p[3]);
            longint d[3];
            longint c[3];
            logic [127:0] s;
            for (int k = 0; k < 3; k++) d[k] = a[k] - p[k];
            c[0] = d[1] * v[2] - d[2] * v[1];
            c[1] = d[2] * v[0] - d[0] * v[2];
            c[2] = d[0] * v[1] - d[1] * v[0];
            s = 0;
            for (int k = 0; k < 3; k++) begin
                if (c[k] < 0) c[k] = -c[k];
                s += 128'(c[k]) * 128'(c[k]);
            end
            return s;
        endfunction

        function void note_request(t_segment seg);
            longint a[3], b[3], v[3], p[3];
            logic [127:0] peak, s, num, vv, t, r;
            t_deviation res;
            a[0] = seg.start_x; a[1] = seg.start_y; a[2] = seg.start_z;
            b[0] = seg.end_x;   b[1] = seg.end_y;   b[2] = seg.end_z;
            for (int k = 0; k < 3; k++) begin
                a[k] = a[k] % (1 << COORD_BITS);
                b[k] = b[k] % (1 << COORD_BITS);
                v[k] = a[k] - b[k];
                p[k] = a[k];
            end
            if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
                res.max_distance = '0;
                res.degenerate   = 1'b1;
            end else begin
                peak = cross_norm(a, v, p);
                for (int k = 0; k < 3; k++) begin
                    while (p[k] < b[k]) begin
                        p[k]++;
                        s = cross_norm(a, v, p);
                        if (s > peak) peak = s;
                    end
                end
                vv = 128'(v[0] * v[0]) + 128'(v[1] * v[1]) + 128'(v[2] * v[2]);
                num = peak << (2 * FRAC_BITS);
                r = 0;
                for (int bit_i = DIST_BITS - 1; bit_i >= 0; bit_i--) begin
                    t = r | (128'(1) << bit_i);
                    if (t * t * vv <= num) r = t;
                end
                res.max_distance = r[DIST_BITS-1:0];
                res.degenerate   = 1'b0;
            end
            pending.insert(pending.size(), res);
        endfunction

        function void check_result(logic [23:0] tdata, logic tuser);
            t_deviation want;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: dist=%0d degenerate=%0b",
                       tdata[DIST_BITS-1:0], tuser);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (tdata[DIST_BITS-1:0] !== want.max_distance) begin
                $error("max_distance: expected %0d, got %0d", want.max_distance,
                       tdata[DIST_BITS-1:0]);
                errors++;
            end
            if (tuser !== want.degenerate) begin
                $error("degenerate: expected %0b, got %0b", want.degenerate, tuser);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_deviation_scoreboard sb = new();
    int  phase = 0;          // 0: sender 30/rx 53, 1: swapped, 2: no idling
    bit  long_holdoff = 1'b0;

    staircase_path_line_deviation_3d_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // receiver side backpressure; the long hold outlasts the longest item
    initial begin
        int stall_pct;
        forever begin
            @(posedge i_clk);
            if (long_holdoff) begin
                m_axis_tready <= 1'b0;
                repeat (60000) @(posedge i_clk);
                long_holdoff = 1'b0;
            end
            stall_pct = (phase == 0) ? 53 : (phase == 1) ? 30 : 0;
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_segment(t_segment seg);
        int idle_pct;
        idle_pct = (phase == 0) ? 30 : (phase == 1) ? 53 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 64'(seg);
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(seg);
    endtask

    function automatic logic [9:0] near(logic [9:0] c, int span);
        int v;
        v = int'(c) + $urandom_range(2 * span) - span;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[9:0];
    endfunction

    function automatic t_segment random_segment();
        t_segment seg;
        int span;
        seg = t_segment'(60'({$urandom, $urandom}));
        // mostly short paths; only a few long ones, to keep the run time bounded
        span = ($urandom_range(99) < 5) ? 1023 : $urandom_range(1, 24);
        seg.end_x = near(seg.start_x, span);
        seg.end_y = near(seg.start_y, span);
        seg.end_z = near(seg.start_z, span);
        if ($urandom_range(19) == 0) begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
            seg.end_z = seg.start_z;
        end
        return seg;
    endfunction

    task automatic send_fields(int ax, int ay, int az, int bx, int by, int bz);
        t_segment seg;
        seg.start_x = IN_BITS'(ax); seg.start_y = IN_BITS'(ay); seg.start_z = IN_BITS'(az);
        seg.end_x = IN_BITS'(bx);   seg.end_y = IN_BITS'(by);   seg.end_z = IN_BITS'(bz);
        send_segment(seg);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate, full span, all axes below, single axes, mixed
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(1023, 1023, 1023, 1023, 1023, 1023);
        send_fields(0, 0, 0, 1023, 1023, 1023);
        send_fields(1023, 1023, 1023, 0, 0, 0);
        send_fields(0, 0, 0, 1023, 0, 0);
        send_fields(0, 0, 0, 0, 1023, 0);
        send_fields(0, 0, 0, 0, 0, 1023);
        send_fields(0, 1023, 0, 1023, 0, 1023);
        send_fields(1023, 0, 1023, 0, 1023, 0);
        send_fields(0, 0, 0, 1, 0, 0);
        send_fields(5, 5, 5, 6, 7, 5);
        send_fields(512, 0, 0, 0, 0, 1023);
        send_fields(0, 0, 1023, 1023, 1023, 0);
        send_fields(0, 0, 0, 1, 1, 1);
        send_fields(100, 200, 300, 99, 220, 290);
        send_fields(1023, 0, 0, 1022, 1023, 0);

        long_holdoff = 1'b1;
        for (int n = 0; n < 100; n++) begin
            phase = (n < 35) ? 0 : (n < 70) ? 1 : 2;
            if (n == 50) begin
                s_axis_tvalid <= 1'b0;
                wait (sb.pending.size() == 0);
                @(posedge i_clk);
            end
            send_segment(random_segment());
        end
        s_axis_tvalid <= 1'b0;

        wait (sb.pending.size() == 0);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("staircase_path_line_deviation_3d_top_tb: done, clean");
        else
            $display("staircase_path_line_deviation_3d_top_tb: done, errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("staircase_path_line_deviation_3d_top_tb: done, errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/spld3_pkg.sv
hw/rtl/staircase_path_line_deviation_3d_top.sv
tb/staircase_path_line_deviation_3d_top_tb.sv
